@@ rtl/epcs_pkg.sv @@
// shared types, constants and sine coefficients for the cross-fade splice core
package epcs_pkg;

  localparam int MAX_FADE = 4096;
  localparam int HOLD_AW  = $clog2(MAX_FADE);

  localparam int SAMPLE_W = 16;
  localparam int FADE_W   = 13;
  localparam int LEN_W    = 20;
  localparam int POS_W    = 21;
  localparam int CFG_W    = 20;
  localparam int ACC_W    = 40;

  // register indexes on the write port
  localparam logic [1:0] CFG_FADE_IDX  = 2'd0;
  localparam logic [1:0] CFG_LEFT_IDX  = 2'd1;
  localparam logic [1:0] CFG_RIGHT_IDX = 2'd2;

  // odd taylor terms of sin((pi/2)x), Q2.30, highest term kept apart
  localparam logic signed [31:0] SIN_C4 = 32'sd172272;

  function automatic logic signed [31:0] sin_coef(input logic [1:0] idx);
    logic signed [31:0] c;
    case (idx)
      2'd0:    c = 32'sd1686629713;
      2'd1:    c = -32'sd693598668;
      2'd2:    c = 32'sd85569306;
      2'd3:    c = -32'sd5026995;
      default: c = 32'sd0;
    endcase
    return c;
  endfunction

  // operations of the shared multiply unit
  typedef enum logic [1:0] {
    MOP_SQ,   // product / 4
    MOP_Q30,  // product / 2^30 toward zero, plus addend
    MOP_Q16,  // product / 2^16 toward zero
    MOP_MAC   // product plus addend
  } mul_op_t;

  typedef struct packed {
    mul_op_t                   op;
    logic signed [31:0]        a;
    logic signed [31:0]        b;
    logic signed [ACC_W-1:0]   c;
  } mul_req_t;

endpackage

@@ rtl/epcs_mul_unit.sv @@
// shared multiply, scale and add unit with a registered result
module epcs_mul_unit (
  input  logic                           clk,
  input  epcs_pkg::mul_req_t             req,
  output logic signed [epcs_pkg::ACC_W-1:0] res
);
  import epcs_pkg::*;

  localparam logic signed [63:0] RND30 = 64'sd1073741823;
  localparam logic signed [63:0] RND16 = 64'sd65535;

  logic signed [63:0]      prod;
  logic signed [63:0]      scaled;
  logic signed [ACC_W-1:0] res_nxt;
  logic signed [ACC_W-1:0] res_r;

  always_comb begin
    prod = req.a * req.b;
    case (req.op)
      MOP_SQ:  scaled = prod >>> 2;
      // bias negative products so the shift truncates toward zero
      MOP_Q30: scaled = (prod + (prod[63] ? RND30 : 64'sd0)) >>> 30;
      MOP_Q16: scaled = (prod + (prod[63] ? RND16 : 64'sd0)) >>> 16;
      MOP_MAC: scaled = prod;
      default: scaled = prod;
    endcase
    res_nxt = ACC_W'(scaled) + req.c;
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

@@ rtl/equal_power_crossfade_splice_core.sv @@
// top level of the equal-power cross-fade splice core
// Usage: samples of the left region, then of the right region, enter on the
// in_ stream one item at a time (in_tdata = sample_in, Q1.15). Spliced samples
// leave on the out_ stream (out_tdata = sample_out, out_tlast = last sample of
// the splice). fade_length, left_length and right_length are written on the
// cfg_ port while the core is idle.
// A plain pass-through item goes to the output state, which loads it into the
// output register. Left tail samples are held in an internal memory and give
// no output; the core is ready again the next cycle. A blended sample passes
// a restoring divider for the phase, two sine evaluations on one shared
// multiplier, a multiply-accumulate of both weighted samples, rounding and
// output. in_tready is high only while the sequencer is idle, so a new item
// waits until the sequencer is done with the last one.
// Reset clears the config registers, the splice position and the output valid.
// The output register holds a finished item while out_tready is low; the
// sequencer waits for it to drain before loading the next result.
module equal_power_crossfade_splice_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample_out
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [epcs_pkg::CFG_W-1:0] cfg_wdata
);
  import epcs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_SQ, ST_HORN, ST_FIN, ST_GAIN,
    ST_MAC1, ST_MAC2, ST_ROUND, ST_OUT
  } state_t;

  state_t state_r;

  logic [FADE_W-1:0] fade_r;
  logic [LEN_W-1:0]  left_r;
  logic [LEN_W-1:0]  right_r;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;
  logic              blend_active_r;
  logic              blend_active_nxt;

  logic signed [SAMPLE_W-1:0] x_r;
  logic                       last_r;
  logic signed [SAMPLE_W-1:0] y_r;
  logic signed [SAMPLE_W-1:0] held_rd_r;
  logic signed [SAMPLE_W-1:0] held_mem [MAX_FADE];

  logic [FADE_W:0]   rem_r;
  logic [FADE_W:0]   div_r;
  logic [15:0]       numlo_r;
  logic [15:0]       quo_r;
  logic [3:0]        cnt_r;
  logic [1:0]        hcnt_r;
  logic              sel_r;
  logic [30:0]       x2_r;
  logic [15:0]       gr_r;
  logic [15:0]       gl_r;

  logic              out_tvalid_r;
  logic [15:0]       out_tdata_r;
  logic              out_tlast_r;

  // item decode
  logic              in_acc;
  logic              fade_ok;
  logic              blend_new;
  logic              blend_cur;
  logic              blend_cond;
  logic [POS_W-1:0]  tail_start;
  logic [POS_W-1:0]  hold_off;
  logic [POS_W-1:0]  fade_off;
  logic              is_hold;
  logic              is_blend;
  logic              is_last;

  // arithmetic
  mul_req_t                mreq;
  logic signed [ACC_W-1:0] mres;
  logic [16:0]             xsel;
  logic [FADE_W+1:0]       rem_sh;
  logic                    rem_ge;
  logic signed [ACC_W-1:0] gain_sh;
  logic [15:0]             gain;
  logic signed [ACC_W-1:0] acc_sh;
  logic signed [SAMPLE_W-1:0] y_sat;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    fade_ok    = (fade_r != '0) && (32'(fade_r) <= MAX_FADE) &&
                 ({7'b0, fade_r} <= left_r);
    blend_new  = fade_ok && ({7'b0, fade_r} <= right_r);
    blend_cur  = (pos_r == '0) ? blend_new : blend_active_r;
    blend_cond = blend_cur && fade_ok;
    tail_start = {1'b0, left_r} - POS_W'(fade_r);
    hold_off   = pos_r - tail_start;
    fade_off   = pos_r - {1'b0, left_r};
    is_hold    = blend_cond && (pos_r >= tail_start) && (pos_r < {1'b0, left_r});
    is_blend   = blend_cond && (pos_r >= {1'b0, left_r}) && (fade_off < POS_W'(fade_r));
    is_last    = ({1'b0, pos_r} + 22'd1) >= ({2'b0, left_r} + {2'b0, right_r});
    pos_nxt    = is_last ? '0 : POS_W'(pos_r + 21'd1);
    blend_active_nxt = is_last ? 1'b0 : blend_cur;
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_hold) begin
      held_mem[hold_off[HOLD_AW-1:0]] <= in_tdata;
    end
    if (in_acc && is_blend) begin
      held_rd_r <= held_mem[fade_off[HOLD_AW-1:0]];
    end
  end

  // restoring divide step: phase = ((2k+1)*2^16 + F) / 2F
  always_comb begin
    rem_sh = {rem_r, numlo_r[15]};
    rem_ge = rem_sh >= {1'b0, div_r};
  end

  // gr uses the phase, gl its complement
  assign xsel = sel_r ? (17'h10000 - {1'b0, quo_r}) : {1'b0, quo_r};

  always_comb begin
    mreq = '{op: MOP_MAC, a: 32'sd0, b: 32'sd0, c: '0};
    case (state_r)
      ST_SQ: begin
        mreq.op = MOP_SQ;
        mreq.a  = 32'(xsel);
        mreq.b  = 32'(xsel);
      end
      ST_HORN: begin
        mreq.op = MOP_Q30;
        mreq.a  = (hcnt_r == 2'd0) ? SIN_C4 : mres[31:0];
        mreq.b  = (hcnt_r == 2'd0) ? {1'b0, mres[30:0]} : {1'b0, x2_r};
        mreq.c  = ACC_W'(sin_coef(2'd3 - hcnt_r));
      end
      ST_FIN: begin
        mreq.op = MOP_Q16;
        mreq.a  = mres[31:0];
        mreq.b  = 32'(xsel);
      end
      ST_MAC1: begin
        mreq.a = {16'b0, gl_r};
        mreq.b = 32'(held_rd_r);
      end
      ST_MAC2: begin
        mreq.a = {16'b0, gr_r};
        mreq.b = 32'(x_r);
        mreq.c = mres;
      end
      default: mreq = '{op: MOP_MAC, a: 32'sd0, b: 32'sd0, c: '0};
    endcase
  end

  epcs_mul_unit u_mul (
    .clk (clk),
    .req (mreq),
    .res (mres)
  );

  // gain: clamp at zero, round half up to Q15, clamp at one
  always_comb begin
    gain_sh = (mres + 40'sd16384) >>> 15;
    if (mres[ACC_W-1]) begin
      gain = 16'd0;
    end else if (gain_sh > 40'sd32768) begin
      gain = 16'd32768;
    end else begin
      gain = gain_sh[15:0];
    end
  end

  always_comb begin
    acc_sh = (mres + 40'sd16384) >>> 15;
    if (acc_sh > 40'sd32767) begin
      y_sat = 16'sh7fff;
    end else if (acc_sh < -40'sd32768) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = acc_sh[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      fade_r         <= '0;
      left_r         <= '0;
      right_r        <= '0;
      pos_r          <= '0;
      blend_active_r <= 1'b0;
      out_tvalid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_FADE_IDX:  fade_r  <= cfg_wdata[FADE_W-1:0];
          CFG_LEFT_IDX:  left_r  <= cfg_wdata[LEN_W-1:0];
          CFG_RIGHT_IDX: right_r <= cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end

      // the output state reloads the valid itself
      if (out_tvalid_r && out_tready && state_r != ST_OUT) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            pos_r          <= pos_nxt;
            blend_active_r <= blend_active_nxt;
            x_r            <= in_tdata;
            last_r         <= is_last;
            if (is_blend) begin
              rem_r   <= {fade_off[FADE_W-1:0], 1'b1};
              div_r   <= {fade_r, 1'b0};
              numlo_r <= 16'(fade_r);
              cnt_r   <= '0;
              sel_r   <= 1'b0;
              state_r <= ST_DIV;
            end else if (!is_hold) begin
              y_r     <= in_tdata;
              state_r <= ST_OUT;
            end
          end
        end
        ST_DIV: begin
          rem_r   <= rem_ge ? (FADE_W+1)'(rem_sh - {1'b0, div_r}) : rem_sh[FADE_W:0];
          quo_r   <= {quo_r[14:0], rem_ge};
          numlo_r <= {numlo_r[14:0], 1'b0};
          cnt_r   <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            state_r <= ST_SQ;
          end
        end
        ST_SQ: begin
          hcnt_r  <= '0;
          state_r <= ST_HORN;
        end
        ST_HORN: begin
          if (hcnt_r == 2'd0) begin
            x2_r <= mres[30:0];
          end
          hcnt_r <= hcnt_r + 2'd1;
          if (hcnt_r == 2'd3) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          state_r <= ST_GAIN;
        end
        ST_GAIN: begin
          if (!sel_r) begin
            gr_r    <= gain;
            sel_r   <= 1'b1;
            state_r <= ST_SQ;
          end else begin
            gl_r    <= gain;
            state_r <= ST_MAC1;
          end
        end
        ST_MAC1: begin
          state_r <= ST_MAC2;
        end
        ST_MAC2: begin
          state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          y_r     <= y_sat;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= y_r;
            out_tlast_r  <= last_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

`ifndef ASSERT_OFF
  a_end_clears_splice: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_last |=> pos_r == '0 && !blend_active_r)
    else $error("splice end did not clear position");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < div_r)
    else $error("divider remainder out of range");

  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MAC1 |-> gr_r <= 16'd32768 && gl_r <= 16'd32768)
    else $error("gain above unity");
`endif

endmodule
